@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define TSH_ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked at every edge, during reset too.
`define TSH_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tsh_pkg.sv @@
// Types and constants of the TCP SYN header builder.
`timescale 1ns / 1ps
`default_nettype none

package tsh_pkg;

   // Header layout.
   localparam int HDR_WORDS   = 10;
   localparam int WORD_IDX_W  = 4;
   localparam logic [WORD_IDX_W-1:0] LAST_IDX = WORD_IDX_W'(HDR_WORDS - 1);

   localparam logic [7:0]  IP_VER_IHL   = 8'h45;
   localparam logic [15:0] IP_TOTAL_LEN = 16'd40;
   localparam logic [7:0]  IP_PROTO_TCP = 8'd6;
   localparam logic [15:0] TCP_HDR_LEN  = 16'd20;
   localparam logic [7:0]  TCP_OFFSET   = 8'h50;

   // Configuration registers.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_TTL    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW = 1'b1;
   localparam logic [7:0]  TTL_RESET    = 8'd64;
   localparam logic [15:0] WINDOW_RESET = 16'd4096;

   // Header fields of one request as they travel down the pipeline.
   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [31:0] seq;
      logic [7:0]  flags;
      logic [15:0] ident;
      logic [7:0]  ttl;
      logic [15:0] window;
   } fields_type;

endpackage

`default_nettype wire

@@ design/tcp_syn_header_builder.sv @@
// Top level of the TCP SYN header builder: checksum pipeline and word serializer.
//
// The block turns one probe request into a 40-byte IPv4 plus TCP header.
// Requests arrive on the req_ channel; req_tdata holds, from the lowest bit
// up, source address, destination address, source port, destination port,
// sequence number, TCP flag byte and IP identification. Each request
// produces ten 32-bit big-endian words on the rsp_ channel, the tenth
// marked by rsp_tlast. The csr_ port sets the TTL (index 0) and the TCP
// window (index 1); write it only while no item is in flight.
// An accepted item passes four register stages (capture, partial sums,
// final sum and first fold, second fold and inversion) and then the
// serializer register before its first word shows on rsp_tvalid.
// The output serializer sends one word per cycle while rsp_tready is
// high; the pipeline stages buffer up to four more items meanwhile, and
// req_tready drops only when all of them are full.
// A stalled rsp_tready holds the current word and backs up the pipeline
// without losing or repeating anything. Synchronous reset empties every
// stage and the serializer and restores TTL 64 and window 4096.
`timescale 1ns / 1ps
`default_nettype none

module tcp_syn_header_builder (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // Fields from bit 0: source_address, dest_address, source_port,
   // dest_port, sequence_number, tcp_flags, ip_identifier.
   input  wire logic [151:0] req_tdata,
   // Result channel.
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // Fields from bit 0: header_word.
   output      logic [31:0]  rsp_tdata,
   output      logic         rsp_tlast,
   // Configuration write port.
   input  wire logic         csr_we,
   input  wire logic [tsh_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tsh_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers.
   logic [7:0]  ttl_ff;
   logic [15:0] window_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff    <= tsh_pkg::TTL_RESET;
         window_ff <= tsh_pkg::WINDOW_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tsh_pkg::REG_TTL:    ttl_ff    <= csr_wdata[7:0];
            tsh_pkg::REG_WINDOW: window_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline registers.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in;
   tsh_pkg::fields_type s1_ff, s2_ff, s3_ff, s4_ff;
   tsh_pkg::fields_type s1_in, s2_in, s3_in, s4_in;
   logic [17:0] ip_part_ff, ip_part_in;
   logic [17:0] addr_sum_ff, addr_sum_in;
   logic [18:0] tcp_part_ff, tcp_part_in;
   logic [16:0] ip_fold_ff, ip_fold_in;
   logic [16:0] tcp_fold_ff, tcp_fold_in;
   logic [15:0] ip_csum_ff, ip_csum_in;
   logic [15:0] tcp_csum_ff, tcp_csum_in;

   // Serializer registers.
   logic                               ser_valid_ff, ser_valid_in;
   logic [tsh_pkg::WORD_IDX_W-1:0]     ser_idx_ff, ser_idx_in;
   logic [31:0] ser_word_ff [tsh_pkg::HDR_WORDS];
   logic [31:0] ser_word_in [tsh_pkg::HDR_WORDS];

   logic ready1, ready2, ready3, ready4;
   logic ser_last, ser_load, rsp_take;
   logic [18:0] ip_sum;
   logic [19:0] tcp_sum;

   assign ser_last = (ser_idx_ff == tsh_pkg::LAST_IDX);
   assign rsp_take = ser_valid_ff && rsp_tready;
   assign ser_load = s4_valid_ff && (!ser_valid_ff || (rsp_take && ser_last));

   // A stage takes new data when it is empty or its content moves on.
   assign ready4 = !s4_valid_ff || ser_load;
   assign ready3 = !s3_valid_ff || ready4;
   assign ready2 = !s2_valid_ff || ready3;
   assign ready1 = !s1_valid_ff || ready2;
   assign req_tready = ready1;

   always_comb begin
      s1_valid_in = ready1 ? req_tvalid  : s1_valid_ff;
      s2_valid_in = ready2 ? s1_valid_ff : s2_valid_ff;
      s3_valid_in = ready3 ? s2_valid_ff : s3_valid_ff;
      s4_valid_in = ready4 ? s3_valid_ff : s4_valid_ff;

      // Stage 1 captures the request and the current configuration.
      s1_in.src    = req_tdata[31:0];
      s1_in.dst    = req_tdata[63:32];
      s1_in.sport  = req_tdata[79:64];
      s1_in.dport  = req_tdata[95:80];
      s1_in.seq    = req_tdata[127:96];
      s1_in.flags  = req_tdata[135:128];
      s1_in.ident  = req_tdata[151:136];
      s1_in.ttl    = ttl_ff;
      s1_in.window = window_ff;

      // Stage 2 forms three partial sums of 16-bit halves. The address
      // sum is shared by the IP header and the TCP pseudo-header.
      s2_in = s1_ff;
      ip_part_in = 18'({tsh_pkg::IP_VER_IHL, 8'h00})
                 + 18'(tsh_pkg::IP_TOTAL_LEN)
                 + 18'(s1_ff.ident)
                 + 18'({s1_ff.ttl, tsh_pkg::IP_PROTO_TCP});
      addr_sum_in = 18'(s1_ff.src[31:16]) + 18'(s1_ff.src[15:0])
                  + 18'(s1_ff.dst[31:16]) + 18'(s1_ff.dst[15:0]);
      tcp_part_in = 19'(s1_ff.sport) + 19'(s1_ff.dport)
                  + 19'(s1_ff.seq[31:16]) + 19'(s1_ff.seq[15:0])
                  + 19'({tsh_pkg::TCP_OFFSET, s1_ff.flags})
                  + 19'(s1_ff.window)
                  + 19'(tsh_pkg::IP_PROTO_TCP)
                  + 19'(tsh_pkg::TCP_HDR_LEN);

      // Stage 3 completes both sums and folds the carries in once.
      s3_in = s2_ff;
      ip_sum  = 19'(ip_part_ff) + 19'(addr_sum_ff);
      tcp_sum = 20'(tcp_part_ff) + 20'(addr_sum_ff);
      ip_fold_in  = 17'(ip_sum[18:16]) + 17'(ip_sum[15:0]);
      tcp_fold_in = 17'(tcp_sum[19:16]) + 17'(tcp_sum[15:0]);

      // Stage 4 adds the last end-around carry and inverts.
      s4_in = s3_ff;
      ip_csum_in  = ~(16'(ip_fold_ff[16])  + ip_fold_ff[15:0]);
      tcp_csum_in = ~(16'(tcp_fold_ff[16]) + tcp_fold_ff[15:0]);

      // Serializer: shift the next word into place, or load a new header.
      ser_valid_in = ser_valid_ff;
      ser_idx_in   = ser_idx_ff;
      for (int k = 0; k < tsh_pkg::HDR_WORDS; k++) begin
         ser_word_in[k] = ser_word_ff[k];
      end
      if (rsp_take) begin
         if (ser_last) begin
            ser_valid_in = 1'b0;
         end else begin
            ser_idx_in = ser_idx_ff + 1'b1;
            for (int k = 0; k < tsh_pkg::HDR_WORDS - 1; k++) begin
               ser_word_in[k] = ser_word_ff[k+1];
            end
         end
      end
      if (ser_load) begin
         ser_valid_in   = 1'b1;
         ser_idx_in     = '0;
         ser_word_in[0] = {tsh_pkg::IP_VER_IHL, 8'h00, tsh_pkg::IP_TOTAL_LEN};
         ser_word_in[1] = {s4_ff.ident, 16'h0000};
         ser_word_in[2] = {s4_ff.ttl, tsh_pkg::IP_PROTO_TCP, ip_csum_ff};
         ser_word_in[3] = s4_ff.src;
         ser_word_in[4] = s4_ff.dst;
         ser_word_in[5] = {s4_ff.sport, s4_ff.dport};
         ser_word_in[6] = s4_ff.seq;
         ser_word_in[7] = 32'h0000_0000;
         ser_word_in[8] = {tsh_pkg::TCP_OFFSET, s4_ff.flags, s4_ff.window};
         ser_word_in[9] = {tcp_csum_ff, 16'h0000};
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         ser_valid_ff <= 1'b0;
         ser_idx_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         ser_valid_ff <= ser_valid_in;
         ser_idx_ff   <= ser_idx_in;
      end
   end

   // Payload registers load only when their stage advances.
   always_ff @(posedge clock) begin
      if (ready1) begin
         s1_ff <= s1_in;
      end
      if (ready2) begin
         s2_ff       <= s2_in;
         ip_part_ff  <= ip_part_in;
         addr_sum_ff <= addr_sum_in;
         tcp_part_ff <= tcp_part_in;
      end
      if (ready3) begin
         s3_ff       <= s3_in;
         ip_fold_ff  <= ip_fold_in;
         tcp_fold_ff <= tcp_fold_in;
      end
      if (ready4) begin
         s4_ff       <= s4_in;
         ip_csum_ff  <= ip_csum_in;
         tcp_csum_ff <= tcp_csum_in;
      end
      for (int k = 0; k < tsh_pkg::HDR_WORDS; k++) begin
         ser_word_ff[k] <= ser_word_in[k];
      end
   end

   assign rsp_tvalid = ser_valid_ff;
   assign rsp_tdata  = ser_word_ff[0];
   assign rsp_tlast  = ser_last;

endmodule

`default_nettype wire

@@ design/tsh_checker.sv @@
// Port-level checks of the TCP SYN header builder and their binding.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tsh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // A stalled word must hold.
   `TSH_ASSERT_RUN(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result word changed while stalled")

   // Reset empties the output.
   `TSH_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid right after reset")

   // A header is never cut short: after a word that is not the last, another follows.
   `TSH_ASSERT_RUN(a_no_gap, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid, "header words interrupted")

   // A header that starts after an idle output begins with the fixed version word.
   `TSH_ASSERT_RUN(a_first_word, clock, reset, $rose(rsp_tvalid) |-> rsp_tdata == 32'h4500_0028 && !rsp_tlast, "header does not start with the version word")

endmodule

bind tcp_syn_header_builder tsh_checker u_tsh_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
